// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CPPM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cppm check failed");

// Next-cycle implication, disabled during reset
`define CPPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cppm check failed");

`endif

// ===== sv/cppm_pkg.sv =====
package cppm_pkg;

	// Input request: one tick or one channel value write
	typedef struct packed {
		logic        kind;
		logic [3:0]  channel_index;
		logic [15:0] channel_value;
	} cppm_in_t;

	// Result for every request
	typedef struct packed {
		logic line_level;
		logic sync_begins;
	} cppm_out_t;

	// Configuration register file contents
	typedef struct packed {
		logic        active_high;
		logic [15:0] pulse_width_us;
		logic [15:0] frame_period_us;
		logic [4:0]  channel_count;
	} cppm_cfg_t;

	// Write request into the channel time table
	typedef struct packed {
		logic        en;
		logic [3:0]  index;
		logic [15:0] value;
	} cppm_wr_t;

	// Request kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

	// Configuration reset values
	localparam logic        RST_ACTIVE_HIGH   = 1'b1;
	localparam logic [15:0] RST_PULSE_WIDTH   = 16'd300;
	localparam logic [15:0] RST_FRAME_PERIOD  = 16'd22500;
	localparam logic [4:0]  RST_CHANNEL_COUNT = 5'd8;

	// Timing state widths and constants
	localparam int TICKS_W = 17;
	localparam int USED_W  = 21;
	localparam logic [TICKS_W-1:0] START_TICKS = 17'd100;
	localparam logic [USED_W-1:0]  USED_MAX    = 21'h1FFFFF;

endpackage

// ===== sv/cppm_chan_table.sv =====
module cppm_chan_table #(
	parameter int MAX_CHANNELS = 16,
	parameter int DEFAULT_SLOT_US = 1500,
	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cppm_pkg::cppm_wr_t  wr,
	input  logic [IDX_W-1:0]    rd_idx,
	output logic [15:0]         rd_data
);
	import cppm_pkg::*;

	logic [15:0] times_q [MAX_CHANNELS];

	// Store channel slot times; writes beyond the table match no entry and drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				times_q[i] <= 16'(DEFAULT_SLOT_US);
			end
		end else begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				if (wr.en && ({2'b00, wr.index} == 6'(i))) begin
					times_q[i] <= wr.value;
				end
			end
		end
	end

	// Read the slot being scheduled
	assign rd_data = times_q[rd_idx];

endmodule

// ===== sv/cppm_sequencer.sv =====
module cppm_sequencer #(
	parameter int MAX_CHANNELS = 16,
	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	localparam int POS_W = $clog2(MAX_CHANNELS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  cppm_pkg::cppm_in_t  item,
	input  cppm_pkg::cppm_cfg_t cfg,
	output logic [IDX_W-1:0]    rd_idx,
	input  logic [15:0]         rd_data,
	output cppm_pkg::cppm_out_t result
);
	import cppm_pkg::*;

	localparam int CMP_W = 6;

	logic               in_pulse_q, in_pulse_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [USED_W-1:0]  used_q, used_d;
	logic [TICKS_W-1:0] ticks_q, ticks_d;

	logic [CMP_W-1:0]   count6;
	logic               last_slot;
	logic               tick_event;
	logic [USED_W:0]    frame_sum;
	logic [USED_W:0]    slot_sum;
	logic [USED_W-1:0]  slot_used;
	logic [15:0]        sync_gap;
	logic [15:0]        slot_gap;
	logic               sync;

	// Clamp the channel count and test for the end of the channel slots
	always_comb begin
		if ({1'b0, cfg.channel_count} > CMP_W'(MAX_CHANNELS)) begin
			count6 = CMP_W'(MAX_CHANNELS);
		end else begin
			count6 = {1'b0, cfg.channel_count};
		end
		last_slot = CMP_W'(pos_q) >= count6;
	end

	assign rd_idx     = pos_q[IDX_W-1:0];
	assign tick_event = (ticks_q[TICKS_W-1:1] == '0);

	// Gap lengths, clamped at zero
	always_comb begin
		frame_sum = (USED_W+1)'(used_q) + (USED_W+1)'(cfg.pulse_width_us);
		if ((USED_W+1)'(cfg.frame_period_us) > frame_sum) begin
			sync_gap = 16'((USED_W+1)'(cfg.frame_period_us) - frame_sum);
		end else begin
			sync_gap = '0;
		end
		if (rd_data > cfg.pulse_width_us) begin
			slot_gap = rd_data - cfg.pulse_width_us;
		end else begin
			slot_gap = '0;
		end
		slot_sum  = (USED_W+1)'(used_q) + (USED_W+1)'(rd_data);
		slot_used = slot_sum[USED_W] ? USED_MAX : slot_sum[USED_W-1:0];
	end

	// Next timing state for a tick
	always_comb begin
		in_pulse_d = in_pulse_q;
		pos_d      = pos_q;
		used_d     = used_q;
		ticks_d    = ticks_q;
		sync       = 1'b0;
		if (step && (item.kind == KIND_TICK)) begin
			if (!tick_event) begin
				ticks_d = ticks_q - 1'b1;
			end else if (!in_pulse_q) begin
				in_pulse_d = 1'b1;
				ticks_d    = {cfg.pulse_width_us, 1'b0};
			end else begin
				in_pulse_d = 1'b0;
				if (last_slot) begin
					pos_d   = '0;
					ticks_d = {sync_gap, 1'b0};
					used_d  = '0;
					sync    = 1'b1;
				end else begin
					pos_d   = pos_q + 1'b1;
					ticks_d = {slot_gap, 1'b0};
					used_d  = slot_used;
				end
			end
		end
	end

	// Hold timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q <= 1'b0;
			pos_q      <= POS_W'(MAX_CHANNELS);
			used_q     <= '0;
			ticks_q    <= START_TICKS;
		end else begin
			in_pulse_q <= in_pulse_d;
			pos_q      <= pos_d;
			used_q     <= used_d;
			ticks_q    <= ticks_d;
		end
	end

	assign result.line_level  = in_pulse_d ^ ~cfg.active_high;
	assign result.sync_begins = sync;

endmodule

// ===== sv/cppm_pulse_train_generator.sv =====
// CPPM pulse train generator. Each request is either one half-microsecond tick or
// a channel time write, and each request yields exactly one result: the line level
// after it, and a flag on the tick that ends the final pulse and opens the sync gap.
// A request is registered on acceptance and processed by the timing sequencer against
// the channel time table when it advances; its result is then loaded into the output
// register. One request is taken every cycle while in_ready is high; in_ready falls
// only while a finished result sits in the output register unclaimed and the next
// request is already waiting behind it. The channel time table is MAX_CHANNELS
// flip-flop entries, loaded with DEFAULT_SLOT_US by reset, so the block takes requests
// right after reset. Write registers only while idle; a new polarity shows on the
// next result, other settings at the next event.
module cppm_pulse_train_generator #(
	parameter int MAX_CHANNELS = 16,
	parameter int DEFAULT_SLOT_US = 1500,
	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [cppm_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [cppm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  cppm_pkg::cppm_in_t                   in_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output cppm_pkg::cppm_out_t                  out_item
);
	import cppm_pkg::*;

	cppm_cfg_t  cfg_q;
	logic       valid_s1;
	cppm_in_t   item_s1;
	logic       out_valid_q;
	cppm_out_t  out_q;
	logic       advance;
	cppm_wr_t   wr;
	logic [IDX_W-1:0] rd_idx;
	logic [15:0] rd_data;
	cppm_out_t  result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high     <= RST_ACTIVE_HIGH;
			cfg_q.pulse_width_us  <= RST_PULSE_WIDTH;
			cfg_q.frame_period_us <= RST_FRAME_PERIOD;
			cfg_q.channel_count   <= RST_CHANNEL_COUNT;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_ACTIVE_HIGH:   cfg_q.active_high     <= cfg_data[0];
				REG_PULSE_WIDTH:   cfg_q.pulse_width_us  <= cfg_data[15:0];
				REG_FRAME_PERIOD:  cfg_q.frame_period_us <= cfg_data[15:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Advance the input stage when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Channel table write for a write request
	assign wr.en    = advance && (item_s1.kind == KIND_WRITE);
	assign wr.index = item_s1.channel_index;
	assign wr.value = item_s1.channel_value;

	cppm_chan_table #(
		.MAX_CHANNELS   (MAX_CHANNELS),
		.DEFAULT_SLOT_US(DEFAULT_SLOT_US)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (rd_idx),
		.rd_data(rd_data)
	);

	cppm_sequencer #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.rd_idx (rd_idx),
		.rd_data(rd_data),
		.result (result)
	);

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sv/cppm_checker.sv =====
`include "assert_macros.svh"

module cppm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input cppm_pkg::cppm_out_t out_item
);

	// Hold a stalled result
	`CPPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

	// An accepted request shows a valid result after the input and result registers
	`CPPM_ASSERT_NEXT(a_in_reaches_out, in_valid && in_ready, ##1 out_valid)

	// A result never appears unless a request was accepted ahead of it through the input and result registers
	`CPPM_ASSERT_IMP(a_no_invented, $rose(out_valid), $past(in_valid && in_ready, 2))

	// Drop ready only while the output is stalled
	`CPPM_ASSERT_IMP(a_ready_low_cause, !in_ready, out_valid && !out_ready)

endmodule

bind cppm_pulse_train_generator cppm_checker u_cppm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
